@@ src/dlbm_pkg.sv @@
package dlbm_pkg;

  // field and register widths
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ShortW     = 12;
  localparam int unsigned LongLowW   = 64;
  localparam int unsigned LongHighW  = 36;
  localparam int unsigned LongW      = LongLowW + LongHighW;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIndexW  = 2;

  // feedback tap of the long register
  localparam int unsigned LongTap    = 36;

  // default keystream bits taken per word
  localparam int unsigned BitsPerItemDef = 8;

  // seed values after reset
  localparam logic [ShortW-1:0]    ShortSeedRst    = 12'hD4B;
  localparam logic [LongLowW-1:0]  LongSeedLowRst  = 64'hAAFE_BBEC_FEBA_AFCA;
  localparam logic [LongHighW-1:0] LongSeedHighRst = 36'hA_BFCB_BAEA;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_SHORT_SEED     = 2'd0,
    CFG_LONG_SEED_LOW  = 2'd1,
    CFG_LONG_SEED_HIGH = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_e;

endpackage

@@ src/dlbm_if.sv @@
// input channel: one open byte per word
interface dlbm_in_if;
  import dlbm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface

// output channel: one masked byte per word
interface dlbm_out_if;
  import dlbm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] cipher_byte;

  modport source (output valid, output cipher_byte, input ready);
  modport sink   (input valid, input cipher_byte, output ready);
endinterface

@@ src/dual_lfsr_byte_masker.sv @@
// Byte stream masker driven by two combined Fibonacci LFSRs (12 and 100 bits).
//
// plain_i is a valid/ready sink of open bytes, masked_o a valid/ready source
// of masked bytes. Each accepted word takes BitsPerItem keystream bits, LSB
// first, from the two shift registers, which advance that many steps at once.
// The result appears in the output register in the cycle after acceptance, and
// a new word is taken every cycle while the output is not stalled: the single
// output register frees as soon as its word is taken.
// When the receiver stalls, the output word holds and plain_i.ready drops
// only while a word is waiting and masked_o.ready is low.
// The configuration port writes the three seed registers by index; any seed
// write reloads both shift registers from all seeds, restarting the stream.
// Writes to an unknown index are ignored. Write seeds only while idle.
// Reset loads the default seeds into the seed and shift registers and
// empties the output register; the block is ready in the first cycle.
module dual_lfsr_byte_masker #(
  parameter int unsigned BitsPerItem = dlbm_pkg::BitsPerItemDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dlbm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [dlbm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  dlbm_in_if.sink                        plain_i,
  dlbm_out_if.source                     masked_o
);
  import dlbm_pkg::*;

  logic [ShortW-1:0]    short_seed_q, short_seed_d;
  logic [LongLowW-1:0]  long_seed_low_q, long_seed_low_d;
  logic [LongHighW-1:0] long_seed_high_q, long_seed_high_d;
  logic                 seed_load;

  logic [ShortW-1:0]    short_shift_q, short_shift_d, short_step;
  logic [LongW-1:0]     long_shift_q, long_shift_d, long_step;
  logic [ByteW-1:0]     key;
  logic                 fb_short, fb_long;

  logic                 out_valid_q, out_valid_d;
  logic [ByteW-1:0]     masked_q, masked_d;
  logic                 in_fire;

  // handshake
  assign plain_i.ready        = !out_valid_q || masked_o.ready;
  assign in_fire              = plain_i.valid && plain_i.ready;
  assign masked_o.valid       = out_valid_q;
  assign masked_o.cipher_byte = masked_q;

  // seed register writes
  always_comb begin
    short_seed_d     = short_seed_q;
    long_seed_low_d  = long_seed_low_q;
    long_seed_high_d = long_seed_high_q;
    seed_load        = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_SHORT_SEED: begin
          short_seed_d = cfg_wdata_i[ShortW-1:0];
          seed_load    = 1'b1;
        end
        CFG_LONG_SEED_LOW: begin
          long_seed_low_d = cfg_wdata_i[LongLowW-1:0];
          seed_load       = 1'b1;
        end
        CFG_LONG_SEED_HIGH: begin
          long_seed_high_d = cfg_wdata_i[LongHighW-1:0];
          seed_load        = 1'b1;
        end
        default: begin
          seed_load = 1'b0;
        end
      endcase
    end
  end

  // unrolled lfsr steps and keystream
  always_comb begin
    short_step = short_shift_q;
    long_step  = long_shift_q;
    key        = '0;
    fb_short   = 1'b0;
    fb_long    = 1'b0;
    for (int i = 0; i < BitsPerItem; i++) begin
      fb_short   = short_step[0] ^ short_step[1];
      fb_long    = long_step[0] ^ long_step[LongTap];
      short_step = {fb_short, short_step[ShortW-1:1]};
      long_step  = {fb_long, long_step[LongW-1:1]};
      if (i < ByteW) begin
        key[i[$clog2(ByteW)-1:0]] = fb_short ^ fb_long;
      end
    end
  end

  // state and output next values
  always_comb begin
    short_shift_d = short_shift_q;
    long_shift_d  = long_shift_q;
    out_valid_d   = out_valid_q;
    masked_d      = masked_q;
    if (seed_load) begin
      short_shift_d = short_seed_d;
      long_shift_d  = {long_seed_high_d, long_seed_low_d};
    end else if (in_fire) begin
      short_shift_d = short_step;
      long_shift_d  = long_step;
    end
    if (in_fire) begin
      out_valid_d = 1'b1;
      masked_d    = plain_i.plain_byte ^ key;
    end else if (masked_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control, seed and shift registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_seed_q     <= ShortSeedRst;
      long_seed_low_q  <= LongSeedLowRst;
      long_seed_high_q <= LongSeedHighRst;
      short_shift_q    <= ShortSeedRst;
      long_shift_q     <= {LongSeedHighRst, LongSeedLowRst};
      out_valid_q      <= 1'b0;
    end else begin
      short_seed_q     <= short_seed_d;
      long_seed_low_q  <= long_seed_low_d;
      long_seed_high_q <= long_seed_high_d;
      short_shift_q    <= short_shift_d;
      long_shift_q     <= long_shift_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    masked_q <= masked_d;
  end

endmodule

@@ src/dlbm_checker.sv @@
module dlbm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [dlbm_pkg::ByteW-1:0]   out_byte_i
);
  import dlbm_pkg::*;

  // an accepted word shows up in the next cycle
  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("accepted word did not reach the output");

  // no output word without an accepted input word
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !($past(out_valid_i) && !$past(out_ready_i)))
      |-> $past(in_valid_i && in_ready_i))
    else $error("output word without an input word");

  // an empty or draining output stage never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled while output stage is free");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_byte_i)))
    else $error("stalled output word changed");

endmodule

bind dual_lfsr_byte_masker dlbm_checker u_dlbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (plain_i.valid),
  .in_ready_i  (plain_i.ready),
  .out_valid_i (masked_o.valid),
  .out_ready_i (masked_o.ready),
  .out_byte_i  (masked_o.cipher_byte)
);
